/* hdl/pdt_pkg.sv */
// Package for the press duration timer: states, constants and segment table.
package pdt_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_CLAMP,
    ST_BCD,
    ST_LOAD
  } pdt_state_t;

  localparam int unsigned DISPLAY_DIGITS = 6;
  localparam int unsigned KEY_BIT        = 2;
  // 10^6 is applied as six times-ten steps
  localparam int unsigned SCALE_STEPS    = 6;
  // 10^6 < 2^20
  localparam int unsigned SCALE_BITS     = 20;
  localparam int unsigned DUR_WIDTH      = 31;
  localparam int unsigned FREQ_WIDTH     = 32;

  localparam logic [DUR_WIDTH-1:0]  DUR_MAX    = 31'h7FFF_FFFF;
  localparam logic [DUR_WIDTH-1:0]  SHOW_LIMIT = DUR_WIDTH'(10 ** DISPLAY_DIGITS - 1);
  localparam int unsigned           BIN_WIDTH  = $clog2(10 ** DISPLAY_DIGITS);
  localparam logic [FREQ_WIDTH-1:0] FREQ_RESET = 32'd50_000_000;

  // Active-low seven-segment code of one decimal digit
  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0:    code = 8'hC0;
      4'd1:    code = 8'hF9;
      4'd2:    code = 8'hA4;
      4'd3:    code = 8'hB0;
      4'd4:    code = 8'h99;
      4'd5:    code = 8'h92;
      4'd6:    code = 8'h82;
      4'd7:    code = 8'hF8;
      4'd8:    code = 8'h80;
      4'd9:    code = 8'h90;
      default: code = 8'hFF;
    endcase
    return code;
  endfunction

endpackage

/* hdl/press_duration_timer_display.sv */
// Top level of the press duration timer with LED and seven-segment outputs.
//
//  channel | direction | handshake          | word
//  in_     | input     | in_valid/in_stall  | key_levels, timestamp (one poll)
//  out_    | output    | out_valid/out_stall| press_us, led_bits, seg_digit0..5
//  cfg_    | input     | cfg_valid/cfg_ready| timer_frequency (32 bits)
//
// A poll that is not a release edge is handled in ST_IDLE. A release edge
// runs the sequencer through ST_MUL, ST_DIV, ST_CLAMP, ST_BCD and ST_LOAD, with
// in_stall high; the bit-serial restoring divider gives one quotient bit a cycle.
// The result word is loaded into the output register in ST_LOAD.
// Reset (rst_n low, synchronous) clears the key state, the start count, the
// sequencer and out_valid, and loads the frequency with 50 MHz.
// While a result waits under out_stall, polls are still taken; a second
// release edge finishes its arithmetic and then holds in_stall high until
// the output register is free.
module press_duration_timer_display #(
  parameter int unsigned LED_WIDTH       = 10,
  parameter int unsigned TIMESTAMP_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // poll channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [3:0]                  in_key_levels,
  input  logic [TIMESTAMP_WIDTH-1:0]  in_timestamp,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pdt_pkg::DUR_WIDTH-1:0] out_press_us,
  output logic [LED_WIDTH-1:0]        out_led_bits,
  output logic [7:0]                  out_seg_digit0,
  output logic [7:0]                  out_seg_digit1,
  output logic [7:0]                  out_seg_digit2,
  output logic [7:0]                  out_seg_digit3,
  output logic [7:0]                  out_seg_digit4,
  output logic [7:0]                  out_seg_digit5,
  // configuration channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pdt_pkg::FREQ_WIDTH-1:0] cfg_data
);
  import pdt_pkg::*;

  // numerator width: ticks * 10^6
  localparam int unsigned NW    = TIMESTAMP_WIDTH + SCALE_BITS;
  localparam int unsigned CNT_W = $clog2(NW + 1);
  localparam int unsigned BCD_W = 4 * DISPLAY_DIGITS;

  pdt_state_t                state_r, state_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      key_was_r, key_was_nxt;
  logic [TIMESTAMP_WIDTH-1:0] start_r, start_nxt;
  logic [FREQ_WIDTH-1:0]     freq_r;
  // ticks, then ticks*10^6, then shifted out as the dividend
  logic [NW-1:0]             acc_r, acc_nxt;
  logic [FREQ_WIDTH-1:0]     rem_r, rem_nxt;
  logic [DUR_WIDTH-1:0]      quo_r, quo_nxt;
  logic                      sat_r, sat_nxt;
  logic [DUR_WIDTH-1:0]      dur_r, dur_nxt;
  logic [BIN_WIDTH-1:0]      bin_r, bin_nxt;
  logic [BCD_W-1:0]          bcd_r, bcd_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [DUR_WIDTH-1:0]      out_dur_r, out_dur_nxt;
  logic [BCD_W-1:0]          out_bcd_r, out_bcd_nxt;

  // shared adder / subtractor
  logic [NW-1:0]             alu_a, alu_b;
  logic                      alu_sub;
  logic [NW:0]               alu_sum;

  logic                      in_take, pressed;
  logic [TIMESTAMP_WIDTH-1:0] tick_diff;
  logic [DUR_WIDTH-1:0]      dur_sel;
  logic [BCD_W-1:0]          bcd_adj;
  logic [DUR_WIDTH:0]        dur_ext;

  assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b ^ {NW{alu_sub}}} + (NW+1)'(alu_sub);

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && !in_stall;
  assign pressed   = !in_key_levels[KEY_BIT];
  assign tick_diff = (in_timestamp > start_r) ? (in_timestamp - start_r)
                                              : (start_r - in_timestamp);
  assign dur_sel   = sat_r ? DUR_MAX : quo_r;

  // add 3 to every digit at five or above before the next shift
  always_comb begin
    for (int d = 0; d < DISPLAY_DIGITS; d++) begin
      bcd_adj[4*d +: 4] = (bcd_r[4*d +: 4] >= 4'd5) ? (bcd_r[4*d +: 4] + 4'd3)
                                                    : bcd_r[4*d +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      key_was_r   <= 1'b0;
      start_r     <= '0;
      freq_r      <= FREQ_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      key_was_r   <= key_was_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        freq_r <= cfg_data;
      end
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    acc_r     <= acc_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    sat_r     <= sat_nxt;
    dur_r     <= dur_nxt;
    bin_r     <= bin_nxt;
    bcd_r     <= bcd_nxt;
    out_dur_r <= out_dur_nxt;
    out_bcd_r <= out_bcd_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    key_was_nxt   = key_was_r;
    start_nxt     = start_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    sat_nxt       = sat_r;
    dur_nxt       = dur_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    out_dur_nxt   = out_dur_r;
    out_bcd_nxt   = out_bcd_r;
    out_valid_nxt = out_valid_r && out_stall;
    alu_a         = acc_r << 3;
    alu_b         = acc_r << 1;
    alu_sub       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          if (pressed && !key_was_r) begin
            start_nxt   = in_timestamp;
            key_was_nxt = 1'b1;
          end else if (!pressed && key_was_r) begin
            key_was_nxt = 1'b0;
            acc_nxt     = NW'(tick_diff);
            cnt_nxt     = '0;
            state_nxt   = ST_MUL;
          end else begin
            key_was_nxt = pressed;
          end
        end
      end
      ST_MUL: begin
        // acc * 10 = acc*8 + acc*2
        acc_nxt = alu_sum[NW-1:0];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SCALE_STEPS - 1)) begin
          cnt_nxt   = '0;
          rem_nxt   = '0;
          quo_nxt   = '0;
          sat_nxt   = 1'b0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // one restoring step: carry out set means shifted rem >= freq
        alu_a   = NW'({rem_r, acc_r[NW-1]});
        alu_b   = NW'(freq_r);
        alu_sub = 1'b1;
        rem_nxt = alu_sum[NW] ? alu_sum[FREQ_WIDTH-1:0]
                              : {rem_r[FREQ_WIDTH-2:0], acc_r[NW-1]};
        acc_nxt = acc_r << 1;
        sat_nxt = sat_r | quo_r[DUR_WIDTH-1];
        quo_nxt = {quo_r[DUR_WIDTH-2:0], alu_sum[NW]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NW - 1)) begin
          state_nxt = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        dur_nxt   = dur_sel;
        bin_nxt   = (dur_sel > SHOW_LIMIT) ? SHOW_LIMIT[BIN_WIDTH-1:0]
                                           : dur_sel[BIN_WIDTH-1:0];
        bcd_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_BCD;
      end
      ST_BCD: begin
        bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[BIN_WIDTH-1]};
        bin_nxt = bin_r << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(BIN_WIDTH - 1)) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // wait for the output register to drain
        if (!out_valid_r || !out_stall) begin
          out_dur_nxt   = dur_r;
          out_bcd_nxt   = bcd_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign dur_ext         = {1'b0, out_dur_r};
  assign out_valid       = out_valid_r;
  assign out_press_us    = out_dur_r;
  assign out_led_bits    = LED_WIDTH'(dur_ext);
  assign out_seg_digit0  = seg_code(out_bcd_r[3:0]);
  assign out_seg_digit1  = seg_code(out_bcd_r[7:4]);
  assign out_seg_digit2  = seg_code(out_bcd_r[11:8]);
  assign out_seg_digit3  = seg_code(out_bcd_r[15:12]);
  assign out_seg_digit4  = seg_code(out_bcd_r[19:16]);
  assign out_seg_digit5  = seg_code(out_bcd_r[23:20]);

endmodule

/* hdl/pdt_checker.sv */
// Port-level assertions for the press duration timer, bound to the top level.
module pdt_checker #(
  parameter int unsigned LED_WIDTH       = 10
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [pdt_pkg::DUR_WIDTH-1:0] out_press_us,
  input logic [LED_WIDTH-1:0]        out_led_bits,
  input logic [7:0]                  out_seg_digit0,
  input logic [7:0]                  out_seg_digit5
);
  import pdt_pkg::*;

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_press_us)
                               && $stable(out_seg_digit0))
    else $error("stalled result word changed");

  // LEDs mirror the low duration bits
  a_led_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_led_bits == LED_WIDTH'({1'b0, out_press_us}))
    else $error("led_bits do not match duration");

  // a new result only comes out of a busy sequencer
  a_new_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a busy cycle");

  // durations past the display range show the clamped nines
  a_clamp_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_press_us > SHOW_LIMIT) |->
      out_seg_digit0 == 8'h90 && out_seg_digit5 == 8'h90)
    else $error("clamped display digits wrong");

endmodule

bind press_duration_timer_display pdt_checker #(
  .LED_WIDTH(LED_WIDTH)
) u_pdt_checker (.*);
